// ===== rtl/core/ehist_pkg.sv =====
package ehist_pkg;

	// default geometry of the histogram store
	localparam int BINS_DEF    = 2048;
	localparam int COUNT_W_DEF = 32;

	// fixed field widths
	localparam int CHAN_W   = 12;
	localparam int ENERGY_W = 16;
	localparam int IDX_W    = 11;
	localparam int OUT_W    = 32;

	localparam logic [CHAN_W-1:0] CHANNEL_RESET = 12'd2048;
	localparam logic [OUT_W-1:0]  OUT_COUNT_MAX = 32'hFFFF_FFFF;

	// item kinds
	localparam logic KIND_EVENT = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic clr_step;  // write zero at the clear pointer
		logic capture;   // latch the accepted word, issue the memory read
		logic update;    // write back, load the result on a read
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;  // clear pointer at the last bin
		logic item_read;   // held item is a read and clear
		logic out_free;    // result register can take a word this cycle
	} sts_t;

endpackage

// ===== rtl/core/ehist_channels.sv =====
// input word: energy event or bin read
interface ehist_in_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [ehist_pkg::ENERGY_W-1:0] energy;
	logic [ehist_pkg::IDX_W-1:0]    read_bin;

	modport source (output valid, kind, energy, read_bin, input ready);
	modport sink   (input valid, kind, energy, read_bin, output ready);
endinterface

// result word: one bin's count
interface ehist_out_if;
	logic                        valid;
	logic                        ready;
	logic [ehist_pkg::IDX_W-1:0] bin_index;
	logic [ehist_pkg::OUT_W-1:0] bin_count;

	modport source (output valid, bin_index, bin_count, input ready);
	modport sink   (input valid, bin_index, bin_count, output ready);
endinterface

// ===== rtl/core/energy_histogram_accumulator.sv =====
// channel   dir  payload                         handshake
// item      in   kind, energy[15:0], read_bin    valid / ready
// result    out  bin_index[10:0], bin_count      valid / ready
// cfg       in   cfg_data[11:0] (channel count)  cfg_we, no wait
//
// Each word is accepted with the memory read, then written back.
// The registered read port of the bin store is why the write-back is a separate step.
// After reset the store is zeroed one bin a cycle, over all BINS bins, with ready low;
// cfg writes are taken during that pass.
// A read word holds in write-back while an earlier result is not taken.
module energy_histogram_accumulator #(
	parameter int BINS    = ehist_pkg::BINS_DEF,
	parameter int COUNT_W = ehist_pkg::COUNT_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ehist_pkg::CHAN_W-1:0] cfg_data,
	ehist_in_if.sink                     item,
	ehist_out_if.source                  result
);

	ehist_pkg::cmd_t cmd;
	ehist_pkg::sts_t sts;
	logic            item_ready;

	assign item.ready = item_ready;

	ehist_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.sts        (sts),
		.item_ready (item_ready),
		.cmd        (cmd)
	);

	ehist_datapath #(
		.BINS    (BINS),
		.COUNT_W (COUNT_W)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.kind      (item.kind),
		.energy    (item.energy),
		.read_bin  (item.read_bin),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.bin_index (result.bin_index),
		.bin_count (result.bin_count)
	);

endmodule

// ===== rtl/core/ehist_ctrl.sv =====
module ehist_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  ehist_pkg::sts_t   sts,
	output logic              item_ready,
	output ehist_pkg::cmd_t   cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_UPD   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		item_ready   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_UPD;
				end
			end
			ST_UPD: begin
				// a read waits here until the result register is free
				if (!sts.item_read || sts.out_free) begin
					cmd.update = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/ehist_datapath.sv =====
module ehist_datapath #(
	parameter int BINS    = ehist_pkg::BINS_DEF,
	parameter int COUNT_W = ehist_pkg::COUNT_W_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ehist_pkg::cmd_t                cmd,
	output ehist_pkg::sts_t                sts,
	input  logic                           cfg_we,
	input  logic [ehist_pkg::CHAN_W-1:0]   cfg_data,
	input  logic                           kind,
	input  logic [ehist_pkg::ENERGY_W-1:0] energy,
	input  logic [ehist_pkg::IDX_W-1:0]    read_bin,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ehist_pkg::IDX_W-1:0]    bin_index,
	output logic [ehist_pkg::OUT_W-1:0]    bin_count
);

	localparam int AW  = $clog2(BINS);
	localparam int CW  = ehist_pkg::ENERGY_W + 1;  // compare width, holds BINS
	localparam int OXW = (COUNT_W > ehist_pkg::OUT_W) ? COUNT_W : ehist_pkg::OUT_W;
	localparam logic [CW-1:0] BINS_L = CW'(BINS);
	localparam logic [AW-1:0] LAST_BIN = AW'(BINS - 1);

	logic [COUNT_W-1:0] mem [BINS];

	logic [ehist_pkg::CHAN_W-1:0] chan_q;
	logic [AW-1:0]                clr_q;
	logic                         kind_q;
	logic                         hit_q;
	logic [AW-1:0]                addr_q;
	logic [ehist_pkg::IDX_W-1:0]  idx_q;
	logic [COUNT_W-1:0]           rdata_q;
	logic                         out_valid_q;
	logic [ehist_pkg::IDX_W-1:0]  bin_index_q;
	logic [ehist_pkg::OUT_W-1:0]  bin_count_q;

	logic [CW-1:0]                energy_w;
	logic [CW-1:0]                bin_w;
	logic                         hit_d;
	logic [AW-1:0]                addr_d;
	logic [COUNT_W-1:0]           wdata;
	logic [OXW-1:0]               rd_ext;
	logic [ehist_pkg::OUT_W-1:0]  count_out;

	// channel count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= ehist_pkg::CHANNEL_RESET;
		end else if (cfg_we) begin
			chan_q <= cfg_data;
		end
	end

	// decode the incoming word: address and in-range check
	always_comb begin
		energy_w = CW'(energy);
		bin_w    = CW'(read_bin);
		if (kind == ehist_pkg::KIND_READ) begin
			hit_d  = bin_w < BINS_L;
			addr_d = bin_w[AW-1:0];
		end else begin
			hit_d  = (energy_w < CW'(chan_q)) && (energy_w < BINS_L);
			addr_d = energy_w[AW-1:0];
		end
	end

	// held word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			hit_q  <= hit_d;
			addr_q <= addr_d;
			idx_q  <= read_bin;
		end
	end

	// write-back value: saturating increment, or zero on a read
	always_comb begin
		if (kind_q == ehist_pkg::KIND_READ) begin
			wdata = '0;
		end else if (rdata_q == {COUNT_W{1'b1}}) begin
			wdata = rdata_q;
		end else begin
			wdata = rdata_q + COUNT_W'(1);
		end
	end

	// histogram store: one write port, registered read
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			mem[clr_q] <= '0;
		end else if (cmd.update && hit_q) begin
			mem[addr_q] <= wdata;
		end
		if (cmd.capture) begin
			rdata_q <= mem[addr_d];
		end
	end

	// clear pointer after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step && clr_q != LAST_BIN) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// reported count: zero for an out-of-range bin, else clipped to the output width
	always_comb begin
		rd_ext = OXW'(rdata_q);
		if (!hit_q) begin
			count_out = '0;
		end else if (rd_ext > OXW'(ehist_pkg::OUT_COUNT_MAX)) begin
			count_out = ehist_pkg::OUT_COUNT_MAX;
		end else begin
			count_out = rd_ext[ehist_pkg::OUT_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update && kind_q == ehist_pkg::KIND_READ) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && kind_q == ehist_pkg::KIND_READ) begin
			bin_index_q <= idx_q;
			bin_count_q <= count_out;
		end
	end

	assign out_valid = out_valid_q;
	assign bin_index = bin_index_q;
	assign bin_count = bin_count_q;

	assign sts.clear_last = clr_q == LAST_BIN;
	assign sts.item_read  = kind_q == ehist_pkg::KIND_READ;
	assign sts.out_free   = !out_valid_q || out_ready;

endmodule
